// ----- src/hdr_color_to_argb8888_macros.svh -----
// ----------------------------------------------------------------------------
// HDR color to ARGB8888 assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HDR_COLOR_TO_ARGB8888_MACROS_SVH
`define HDR_COLOR_TO_ARGB8888_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/hca_pkg.sv -----
// ----------------------------------------------------------------------------
// HDR color to ARGB8888 package
// Widths, pipeline depth and the stage load bundle shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hca_pkg;

	localparam int DATA_W      = 32;
	localparam int BYTE_W      = 8;
	localparam int NUM_CHAN    = 4;
	localparam int DEN_W       = DATA_W - 1;
	localparam int NUM_W       = DEN_W + BYTE_W;
	localparam int DIV_STEPS   = BYTE_W;
	localparam int NUM_STG     = DIV_STEPS + 3;
	localparam int IN_TDATA_W  = NUM_CHAN * DATA_W;
	localparam int OUT_TDATA_W = NUM_CHAN * BYTE_W;

	typedef struct packed {
		logic                 out_ld;
		logic [DIV_STEPS-1:0] div_ld;
		logic                 prep_ld;
		logic                 in_ld;
	} hca_ld_t;

endpackage

`default_nettype wire

// ----- src/hca_front.sv -----
// ----------------------------------------------------------------------------
// HDR color front stage
// Registers the incoming channels together with the largest color channel
// and the flag that says whether the colors must be scaled down.
// ----------------------------------------------------------------------------
`default_nettype none

module hca_front
	import hca_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     ld,
	input  logic signed [DATA_W-1:0] red_in,
	input  logic signed [DATA_W-1:0] green_in,
	input  logic signed [DATA_W-1:0] blue_in,
	input  logic signed [DATA_W-1:0] alpha_in,
	output logic signed [DATA_W-1:0] red_s1,
	output logic signed [DATA_W-1:0] green_s1,
	output logic signed [DATA_W-1:0] blue_s1,
	output logic signed [DATA_W-1:0] alpha_s1,
	output logic signed [DATA_W-1:0] peak_s1,
	output logic                     scale_s1
);

	localparam logic signed [DATA_W-1:0] ONE_S = DATA_W'(1) << FRAC_BITS;

	logic signed [DATA_W-1:0] peak_rg;
	logic signed [DATA_W-1:0] peak_c;

	always_comb begin
		peak_rg = (green_in > red_in) ? green_in : red_in;
		peak_c  = (blue_in > peak_rg) ? blue_in : peak_rg;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
			alpha_s1 <= alpha_in;
			peak_s1  <= peak_c;
			scale_s1 <= peak_c > ONE_S;
		end
	end

endmodule

`default_nettype wire

// ----- src/hca_lane.sv -----
// ----------------------------------------------------------------------------
// HDR color channel lane
// Clamps one channel, forms channel * 255 and divides it by the peak or by
// 1.0 with a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hca_lane
	import hca_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  hca_ld_t                  ld,
	input  logic signed [DATA_W-1:0] chan,
	input  logic signed [DATA_W-1:0] peak,
	input  logic                     scale,
	output logic [BYTE_W-1:0]        level
);

	localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;

	logic [DEN_W-1:0] c_pos;
	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;

	logic [NUM_W-1:0]  rem_s [DIV_STEPS];
	logic [DEN_W-1:0]  den_s [DIV_STEPS];
	logic [BYTE_W-1:0] quo_s [DIV_STEPS];

	// Only alpha can exceed 1.0 without scaling; the clamp keeps it in range.
	always_comb begin
		if (chan <= 0) begin
			c_pos = '0;
		end else if (!scale && (chan > $signed({1'b0, ONE}))) begin
			c_pos = ONE;
		end else begin
			c_pos = chan[DEN_W-1:0];
		end
		num_c = {c_pos, BYTE_W'(0)} - NUM_W'(c_pos);
		den_c = scale ? peak[DEN_W-1:0] : ONE;
	end

	always_ff @(posedge clk) begin
		if (ld.prep_ld) begin
			rem_s[0] <= num_c;
			den_s[0] <= den_c;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - j;

		logic [NUM_W-1:0]  dsh;
		logic              ge;
		logic [BYTE_W-1:0] quo_prev;

		if (j == 0) begin : g_first
			assign quo_prev = '0;
		end else begin : g_rest
			assign quo_prev = quo_s[j-1];
		end

		always_comb begin
			dsh = NUM_W'(den_s[j]) << SH;
			ge  = rem_s[j] >= dsh;
		end

		always_ff @(posedge clk) begin
			if (ld.div_ld[j]) begin
				quo_s[j] <= {quo_prev[BYTE_W-2:0], ge};
			end
		end

		if (j < DIV_STEPS - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (ld.div_ld[j]) begin
					rem_s[j+1] <= ge ? (rem_s[j] - dsh) : rem_s[j];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	assign level = quo_s[DIV_STEPS-1];

endmodule

`default_nettype wire

// ----- src/hca_merge.sv -----
// ----------------------------------------------------------------------------
// HDR color output merge
// Gathers the four lane bytes into the registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hca_merge
	import hca_pkg::*;
(
	input  logic                   clk,
	input  logic                   ld,
	input  logic [BYTE_W-1:0]      alpha_level,
	input  logic [BYTE_W-1:0]      red_level,
	input  logic [BYTE_W-1:0]      green_level,
	input  logic [BYTE_W-1:0]      blue_level,
	output logic [OUT_TDATA_W-1:0] tdata_q
);

	always_ff @(posedge clk) begin
		if (ld) begin
			tdata_q <= {blue_level, green_level, red_level, alpha_level};
		end
	end

endmodule

`default_nettype wire

// ----- src/hdr_color_to_argb8888.sv -----
// ----------------------------------------------------------------------------
// HDR color to ARGB8888 converter
// Converts one signed fixed-point RGBA color per beat into four bytes.
// ----------------------------------------------------------------------------
// Each input beat on s_axis carries red, green, blue and alpha as signed
// fixed-point words with FRAC_BITS fraction bits. Each output beat on m_axis
// carries alpha, red, green and blue bytes. If the largest color channel is
// above 1.0, the colors are divided by it; negative colors become zero and
// alpha is clamped to the range 0 to 1.0.
// The pipeline has 11 stages: a front stage that finds the peak, a stage per
// lane that forms channel * 255, eight restoring divider stages that each
// resolve one quotient bit, and the output register. Throughput is one beat
// per cycle while the receiver does not stall.
// Four lanes work side by side, one per channel, and the merge stage packs
// their bytes. Every stage has its own valid bit, so a stalled receiver only
// fills empty stages; s_axis_tready falls once all 11 stages hold a beat.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hdr_color_to_argb8888_macros.svh"

module hdr_color_to_argb8888
	import hca_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0: red_in, green_in, blue_in, alpha_in.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0: alpha_byte, red_byte, green_byte, blue_byte.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic signed [DATA_W-1:0] ONE_S = DATA_W'(1) << FRAC_BITS;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG:0]   rdy;
	logic [NUM_STG-1:0] vin;
	logic [NUM_STG-1:0] ld_vec;
	hca_ld_t            ld_s;

	logic signed [DATA_W-1:0] red_s1;
	logic signed [DATA_W-1:0] green_s1;
	logic signed [DATA_W-1:0] blue_s1;
	logic signed [DATA_W-1:0] alpha_s1;
	logic signed [DATA_W-1:0] peak_s1;
	logic                     scale_s1;

	logic [BYTE_W-1:0] alpha_level;
	logic [BYTE_W-1:0] red_level;
	logic [BYTE_W-1:0] green_level;
	logic [BYTE_W-1:0] blue_level;

	always_comb begin
		rdy[NUM_STG] = m_axis_tready;
		for (int i = NUM_STG - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign vin    = {vld_q[NUM_STG-2:0], s_axis_tvalid};
	assign ld_vec = rdy[NUM_STG-1:0] & vin;

	always_comb begin
		ld_s.in_ld   = ld_vec[0];
		ld_s.prep_ld = ld_vec[1];
		ld_s.div_ld  = ld_vec[NUM_STG-2:2];
		ld_s.out_ld  = ld_vec[NUM_STG-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy[NUM_STG-1:0] & vin) | (~rdy[NUM_STG-1:0] & vld_q);
		end
	end

	assign s_axis_tready = rdy[0];
	assign m_axis_tvalid = vld_q[NUM_STG-1];

	hca_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk     (clk),
		.ld      (ld_s.in_ld),
		.red_in  (s_axis_tdata[DATA_W-1:0]),
		.green_in(s_axis_tdata[2*DATA_W-1:DATA_W]),
		.blue_in (s_axis_tdata[3*DATA_W-1:2*DATA_W]),
		.alpha_in(s_axis_tdata[4*DATA_W-1:3*DATA_W]),
		.red_s1  (red_s1),
		.green_s1(green_s1),
		.blue_s1 (blue_s1),
		.alpha_s1(alpha_s1),
		.peak_s1 (peak_s1),
		.scale_s1(scale_s1)
	);

	hca_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_alpha (
		.clk  (clk),
		.ld   (ld_s),
		.chan (alpha_s1),
		.peak (ONE_S),
		.scale(1'b0),
		.level(alpha_level)
	);

	hca_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_red (
		.clk  (clk),
		.ld   (ld_s),
		.chan (red_s1),
		.peak (peak_s1),
		.scale(scale_s1),
		.level(red_level)
	);

	hca_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_green (
		.clk  (clk),
		.ld   (ld_s),
		.chan (green_s1),
		.peak (peak_s1),
		.scale(scale_s1),
		.level(green_level)
	);

	hca_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_blue (
		.clk  (clk),
		.ld   (ld_s),
		.chan (blue_s1),
		.peak (peak_s1),
		.scale(scale_s1),
		.level(blue_level)
	);

	hca_merge u_merge (
		.clk        (clk),
		.ld         (ld_s.out_ld),
		.alpha_level(alpha_level),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level),
		.tdata_q    (m_axis_tdata)
	);

	`HCA_ASSERT_NEXT(a_in_fills_front, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted beat lost at front stage")
	`HCA_ASSERT_NEXT(a_out_load_valid, ld_s.out_ld, m_axis_tvalid, "output load did not raise tvalid")
	`HCA_ASSERT_NOW(a_no_overwrite, 1'b1, ((vld_q & ~rdy[NUM_STG:1]) & ld_vec) == '0, "stage overwritten while blocked")

endmodule

`default_nettype wire
